@@ src/fsr_pkg.sv @@
`timescale 1ns / 1ps

package fsr_pkg;

    // Buffer and header geometry.
    localparam int BUFFER_BYTES = 512;
    localparam int HEADER_BYTES = 16;

    // Widths of the fields and counters.
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 10;
    localparam int LEN_W    = 16;
    localparam int INDEX_W  = 16;
    localparam int CRC_W    = 16;
    localparam int MAXP_W   = 9;
    localparam int STATUS_W = 3;
    localparam int PHASE_W  = 2;

    // CRC16-Modbus constants.
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // Reset value of the payload limit.
    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RESET = 9'd256;

    // Header byte positions.
    localparam logic [COUNT_W-1:0] POS_LEN_HI   = 10'd12;
    localparam logic [COUNT_W-1:0] POS_LEN_LO   = 10'd13;
    localparam logic [COUNT_W-1:0] POS_INDEX_HI = 10'd14;
    localparam logic [COUNT_W-1:0] POS_LAST_HDR = 10'd15;

    // Characters of the date field.
    localparam logic [BYTE_W-1:0] CHAR_DASH   = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UPPERA = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPERZ = 8'h5A;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_ACK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DATE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LENGTH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INDEX  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CRC    = 3'd4;

    // Receive phases.
    localparam logic [PHASE_W-1:0] PHASE_HEADER  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_PAYLOAD = 2'd1;

    // One byte held in the input register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } item_t;

    // One judged segment.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
    } result_t;

    // Feeds one byte into a reflected CRC16 with polynomial 0xA001.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Checks one character of the "yyyy-mm-dd-L" date field.
    function automatic logic date_byte_ok(input logic [COUNT_W-1:0] pos,
                                          input logic [BYTE_W-1:0] b);
        logic ok;
        if (pos == 10'd4 || pos == 10'd7 || pos == 10'd10)
            ok = (b == CHAR_DASH);
        else if (pos == 10'd11)
            ok = (b >= CHAR_UPPERA) && (b <= CHAR_UPPERZ);
        else
            ok = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        return ok;
    endfunction

endpackage

@@ src/fsr_in_reg.sv @@
`timescale 1ns / 1ps

module fsr_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_byte,
    input  logic                 take,
    output fsr_pkg::item_t       item
);
    import fsr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              accept;

    // The register is free when empty or when its byte leaves this cycle.
    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    // Valid flag of the held byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Byte captured on each input transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= rx_byte;
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

@@ src/fsr_core.sv @@
`timescale 1ns / 1ps

module fsr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [8:0]           cfg_data,
    input  fsr_pkg::item_t       item,
    input  logic                 out_busy,
    output logic                 take,
    output logic                 res_valid,
    output fsr_pkg::result_t     res
);
    import fsr_pkg::*;

    logic [MAXP_W-1:0]  max_payload_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               date_ok_reg, date_ok_next;
    logic [LEN_W-1:0]   segment_length_reg, segment_length_next;
    logic [INDEX_W-1:0] index_field_reg, index_field_next;
    logic [CRC_W-1:0]   running_crc_reg, running_crc_next;
    logic [BYTE_W-1:0]  crc_low_byte_reg, crc_low_byte_next;
    logic [INDEX_W-1:0] expected_index_reg, expected_index_next;

    logic [BYTE_W-1:0]  b;
    logic [CRC_W-1:0]   crc_fed;
    logic [COUNT_W-1:0] count_inc;
    logic               produce;
    logic               judge_en;
    logic [STATUS_W-1:0] oversize_status;
    logic               oversize;

    // Inputs of the segment judgement.
    logic               j_date_ok;
    logic [LEN_W-1:0]   j_len;
    logic [INDEX_W-1:0] j_index;
    logic [CRC_W-1:0]   j_crc;
    logic [CRC_W-1:0]   j_recv;
    logic [STATUS_W-1:0] j_status;
    logic [INDEX_W-1:0] j_exp_next;

    assign b         = item.data;
    assign crc_fed   = crc_feed(running_crc_reg, b);
    assign count_inc = byte_count_reg + 10'd1;
    assign oversize_status = ST_LENGTH;

    // Judgement of a complete segment: date, length, index, then CRC.
    always_comb
    begin
        j_exp_next = expected_index_reg;
        if (!j_date_ok)
            j_status = ST_DATE;
        else if (j_len < 16'd2 ||
                 ({1'b0, j_len} - 17'd2) > {8'b0, max_payload_reg})
            j_status = ST_LENGTH;
        else if (expected_index_reg != '0 && j_index != expected_index_reg)
        begin
            j_status   = ST_INDEX;
            j_exp_next = '0;
        end
        else
        begin
            j_exp_next = j_index + 16'd1;
            j_status   = (j_crc != j_recv) ? ST_CRC : ST_ACK;
        end
    end

    // Per-byte parsing of header and payload.
    always_comb
    begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        date_ok_next        = date_ok_reg;
        segment_length_next = segment_length_reg;
        index_field_next    = index_field_reg;
        running_crc_next    = running_crc_reg;
        crc_low_byte_next   = crc_low_byte_reg;
        produce             = 1'b0;
        judge_en            = 1'b0;
        oversize            = 1'b0;
        j_date_ok           = date_ok_reg;
        j_len               = segment_length_reg;
        j_index             = index_field_reg;
        j_crc               = running_crc_reg;
        j_recv              = {b, crc_low_byte_reg};
        unique case (phase_reg)
            PHASE_HEADER:
            begin
                running_crc_next = crc_fed;
                if (byte_count_reg < POS_LEN_HI)
                begin
                    if (!date_byte_ok(byte_count_reg, b))
                        date_ok_next = 1'b0;
                end
                else if (byte_count_reg == POS_LEN_HI)
                    segment_length_next = {b, segment_length_reg[7:0]};
                else if (byte_count_reg == POS_LEN_LO)
                    segment_length_next = {segment_length_reg[15:8], b};
                else if (byte_count_reg == POS_INDEX_HI)
                    index_field_next = {b, index_field_reg[7:0]};
                else
                    index_field_next = {index_field_reg[15:8], b};
                byte_count_next = count_inc;
                j_date_ok = date_ok_next;
                j_len     = segment_length_next;
                j_index   = index_field_next;
                j_crc     = crc_fed;
                j_recv    = {8'h00, crc_low_byte_reg};
                if (byte_count_reg == POS_LAST_HDR)
                begin
                    if ((17'(HEADER_BYTES) + {1'b0, segment_length_next})
                        > 17'(BUFFER_BYTES))
                    begin
                        produce  = 1'b1;
                        oversize = 1'b1;
                    end
                    else if (segment_length_next != '0)
                        phase_next = PHASE_PAYLOAD;
                    else
                    begin
                        produce  = 1'b1;
                        judge_en = 1'b1;
                    end
                end
            end
            PHASE_PAYLOAD:
            begin
                if ({7'b0, byte_count_reg} <
                    17'(HEADER_BYTES - 2) + {1'b0, segment_length_reg})
                    running_crc_next = crc_fed;
                else if ({7'b0, byte_count_reg} ==
                         17'(HEADER_BYTES - 2) + {1'b0, segment_length_reg})
                    crc_low_byte_next = b;
                byte_count_next = count_inc;
                if ({7'b0, count_inc} ==
                    17'(HEADER_BYTES) + {1'b0, segment_length_reg})
                begin
                    produce  = 1'b1;
                    judge_en = 1'b1;
                end
            end
            default:
            begin
                phase_next = PHASE_HEADER;
            end
        endcase
        if (judge_en)
            expected_index_next = j_exp_next;
        else
            expected_index_next = expected_index_reg;
        // A judged segment sends the parser back to the start of a header.
        if (produce)
        begin
            phase_next        = PHASE_HEADER;
            byte_count_next   = '0;
            date_ok_next      = 1'b1;
            running_crc_next  = CRC_INIT;
            crc_low_byte_next = '0;
        end
    end

    // A byte stalls only when it completes a segment and the output is full.
    assign take       = item.valid && !(produce && out_busy);
    assign res_valid  = take && produce;
    assign res.status = oversize ? oversize_status : j_status;
    assign res.index  = index_field_next;

    // Parser state and the payload limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg    <= MAX_PAYLOAD_RESET;
            phase_reg          <= PHASE_HEADER;
            byte_count_reg     <= '0;
            date_ok_reg        <= 1'b1;
            segment_length_reg <= '0;
            index_field_reg    <= '0;
            running_crc_reg    <= CRC_INIT;
            crc_low_byte_reg   <= '0;
            expected_index_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                max_payload_reg <= cfg_data;
            if (take)
            begin
                phase_reg          <= phase_next;
                byte_count_reg     <= byte_count_next;
                date_ok_reg        <= date_ok_next;
                segment_length_reg <= segment_length_next;
                index_field_reg    <= index_field_next;
                running_crc_reg    <= running_crc_next;
                crc_low_byte_reg   <= crc_low_byte_next;
                expected_index_reg <= expected_index_next;
            end
        end
    end

endmodule

@@ src/fsr_out_reg.sv @@
`timescale 1ns / 1ps

module fsr_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  fsr_pkg::result_t     res,
    output logic                 out_busy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           status,
    output logic [15:0]          segment_index
);
    import fsr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A held result blocks a new one until its transfer completes.
    assign out_busy = valid_reg && !out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    // Valid flag of the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

    assign out_valid     = valid_reg;
    assign status        = res_reg.status;
    assign segment_index = res_reg.index;

endmodule

@@ src/firmware_segment_receiver.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_data[8:0] (max_payload)
// in        in         in_valid / in_ready    rx_byte[7:0]
// out       out        out_valid / out_ready  status[2:0], segment_index[15:0]
//
// One byte is accepted per cycle unless a held result stalls it; the result of
// the byte that completes a segment passes from the input register through
// the single parsing stage to the result register, from which it is offered
// on the output.
// Reset is asynchronous and active low; it restores the payload limit to 256.
// A held result stalls only the byte that completes the next segment.

module firmware_segment_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] segment_index
);
    import fsr_pkg::*;

    item_t   item;
    result_t res;
    logic    take;
    logic    res_valid;
    logic    out_busy;
    logic    cfg_we;

    // The configuration register takes every write transfer.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    fsr_in_reg u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .take     (take),
        .item     (item)
    );

    fsr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .item      (item),
        .out_busy  (out_busy),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    fsr_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .out_busy      (out_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .segment_index (segment_index)
    );

    // The input side stalls only with a byte held and a result waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item.valid && out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    // A judged segment always reaches the result register.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> out_valid)
        else $error("judged segment did not reach the output");

    // Only defined status codes are offered.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_CRC))
        else $error("undefined status code on the output");

endmodule

@@ test/tb_firmware_segment_receiver.sv @@
`timescale 1ns / 1ps

module tb_firmware_segment_receiver;
    import fsr_pkg::*;

    localparam int MAX_GAP       = 13;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_BYTES  = 400;
    localparam int RANDOM_PHASES = 6;
    localparam int SHORT_PAYLOAD = 24;
    localparam int MAX_LEN_FIELD = BUFFER_BYTES - HEADER_BYTES;
    localparam int DATE_BYTES    = 12;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [MAXP_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   rx_byte;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  segment_index;

    firmware_segment_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .segment_index (segment_index)
    );

    // Shadow copy of the receiver state, advanced on every accepted byte.
    logic [PHASE_W-1:0] rx_phase;
    logic [COUNT_W-1:0] rx_count;
    logic               rx_date_ok;
    logic [LEN_W-1:0]   rx_length;
    logic [INDEX_W-1:0] hdr_index;
    logic [CRC_W-1:0]   rx_crc;
    logic [BYTE_W-1:0]  rx_crc_lo;
    logic [INDEX_W-1:0] next_index;
    logic [MAXP_W-1:0]  max_payload;

    // Segment verdicts still to come out of the block, oldest first.
    result_t verdict_q[$];

    int error_count   = 0;
    int bytes_sent    = 0;
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_request   = 1'b0;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("[firmware_segment_receiver] ERROR");
        $finish;
    end

    // One byte of the reflected CRC16 with polynomial 0xA001.
    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8)
        begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // Character class required at each position of the date field.
    function automatic bit date_char_valid(input int pos, input logic [BYTE_W-1:0] b);
        case (pos)
            4, 7, 10: return b == CHAR_DASH;
            11:       return (b >= CHAR_UPPERA) && (b <= CHAR_UPPERZ);
            default:  return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        endcase
    endfunction

    // Return to the start of a header.
    function automatic void rx_restart();
        rx_phase   = PHASE_HEADER;
        rx_count   = '0;
        rx_date_ok = 1'b1;
        rx_crc     = CRC_INIT;
        rx_crc_lo  = '0;
    endfunction

    // Checks of a complete segment in their fixed order; the index advances
    // before the CRC is compared.
    function automatic logic [STATUS_W-1:0] judge_segment(input logic [BYTE_W-1:0] crc_hi);
        if (!rx_date_ok)
            return ST_DATE;
        if (rx_length < 2 || int'(rx_length) - 2 > int'(max_payload))
            return ST_LENGTH;
        if (next_index != 0 && hdr_index != next_index)
        begin
            next_index = '0;
            return ST_INDEX;
        end
        next_index = hdr_index + 1'b1;
        if (rx_crc != {crc_hi, rx_crc_lo})
            return ST_CRC;
        return ST_ACK;
    endfunction

    // Advances the shadow state by one accepted byte and queues any verdict.
    function automatic void track_rx_byte(input logic [BYTE_W-1:0] b);
        int                pos;
        bit                complete;
        logic [BYTE_W-1:0] crc_hi;
        result_t           verdict;
        pos      = int'(rx_count);
        complete = 1'b0;
        crc_hi   = 8'h00;
        if (rx_phase == PHASE_HEADER)
        begin
            rx_crc = crc16_step(rx_crc, b);
            if (pos < DATE_BYTES)
            begin
                if (!date_char_valid(pos, b))
                    rx_date_ok = 1'b0;
            end
            else if (pos == POS_LEN_HI)
                rx_length[15:8] = b;
            else if (pos == POS_LEN_LO)
                rx_length[7:0] = b;
            else if (pos == POS_INDEX_HI)
                hdr_index[15:8] = b;
            else
                hdr_index[7:0] = b;
            rx_count = rx_count + 1'b1;
            if (pos + 1 == HEADER_BYTES)
            begin
                // An oversized segment is rejected as soon as its header ends.
                if (HEADER_BYTES + int'(rx_length) > BUFFER_BYTES)
                begin
                    verdict.status = ST_LENGTH;
                    verdict.index  = hdr_index;
                    verdict_q.push_back(verdict);
                    rx_restart();
                end
                else if (rx_length != 0)
                    rx_phase = PHASE_PAYLOAD;
                else
                    complete = 1'b1;
            end
        end
        else
        begin
            if (pos < HEADER_BYTES - 2 + int'(rx_length))
                rx_crc = crc16_step(rx_crc, b);
            else if (pos == HEADER_BYTES - 2 + int'(rx_length))
                rx_crc_lo = b;
            rx_count = rx_count + 1'b1;
            if (pos + 1 == HEADER_BYTES + int'(rx_length))
            begin
                complete = 1'b1;
                crc_hi   = b;
            end
        end
        if (complete)
        begin
            verdict.status = judge_segment(crc_hi);
            verdict.index  = hdr_index;
            verdict_q.push_back(verdict);
            rx_restart();
        end
    endfunction

    // Index that passes the sequence check.
    function automatic logic [INDEX_W-1:0] good_index();
        if (next_index != 0)
            return next_index;
        return INDEX_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Mostly short payloads, now and then one up to the limit.
    function automatic int pick_payload();
        int cap;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, int'(max_payload));
        cap = (int'(max_payload) < SHORT_PAYLOAD) ? int'(max_payload) : SHORT_PAYLOAD;
        return $urandom_range(0, cap);
    endfunction

    // Offers one byte and waits for its transfer. Valid is left high so that
    // a following byte without a gap keeps it asserted.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        track_rx_byte(b);
    endtask

    // Builds and sends one segment. The tail after the header follows the
    // length field, with the CRC in its last two bytes where there is room.
    task automatic send_segment(input logic [INDEX_W-1:0] idx, input logic [LEN_W-1:0] len_field,
                                input bit bad_date, input bit bad_crc);
        logic [BYTE_W-1:0] seg[$];
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b;
        int                tail;
        int                bad_pos;
        for (int p = 0; p < DATE_BYTES; p++)
        begin
            if (p == 4 || p == 7 || p == 10)
                seg.push_back(CHAR_DASH);
            else if (p == 11)
                seg.push_back(BYTE_W'(CHAR_UPPERA + $urandom_range(0, 25)));
            else
                seg.push_back(BYTE_W'(CHAR_ZERO + $urandom_range(0, 9)));
        end
        if (bad_date)
        begin
            bad_pos = $urandom_range(0, DATE_BYTES - 1);
            do
                b = BYTE_W'($urandom_range(0, 255));
            while (date_char_valid(bad_pos, b));
            seg[bad_pos] = b;
        end
        seg.push_back(len_field[15:8]);
        seg.push_back(len_field[7:0]);
        seg.push_back(idx[15:8]);
        seg.push_back(idx[7:0]);
        tail = (HEADER_BYTES + int'(len_field) > BUFFER_BYTES) ? 0 : int'(len_field);
        if (tail >= 2)
        begin
            repeat (tail - 2)
                seg.push_back(BYTE_W'($urandom_range(0, 255)));
            crc = CRC_INIT;
            foreach (seg[i])
                crc = crc16_step(crc, seg[i]);
            if (bad_crc)
                crc = crc ^ CRC_W'($urandom_range(1, 16'hFFFF));
            seg.push_back(crc[7:0]);
            seg.push_back(crc[15:8]);
        end
        else if (tail == 1)
            seg.push_back(BYTE_W'($urandom_range(0, 255)));
        foreach (seg[i])
            send_byte(seg[i]);
    endtask

    // Lets every queued verdict come out, then lets the pipeline settle.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the payload limit while the block is idle at a segment boundary.
    task automatic write_max_payload(input logic [MAXP_W-1:0] value);
        wait_until_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        max_payload  = value;
    endtask

    // Index sequencing: check off at zero, advance, mismatch, 16-bit wrap.
    task automatic test_index_sequence();
        send_segment(16'h0001, 16'd2, 1'b0, 1'b0);
        send_segment(16'h0002, 16'd6, 1'b0, 1'b0);
        send_segment(16'h0009, 16'd4, 1'b0, 1'b0);
        send_segment(16'hFFFF, 16'd5, 1'b0, 1'b0);
        send_segment(16'h0000, 16'd2, 1'b0, 1'b0);
        send_segment(16'h0001, 16'd3, 1'b0, 1'b0);
    endtask

    // Each error status, and the order in which the checks take precedence.
    task automatic test_segment_errors();
        send_segment(next_index, 16'd10, 1'b0, 1'b1);
        send_segment(next_index, 16'd4, 1'b1, 1'b0);
        send_segment(next_index, 16'd2, 1'b0, 1'b0);
        send_segment(next_index + 16'd5, 16'd4, 1'b1, 1'b1);
        send_segment(next_index, 16'd0, 1'b0, 1'b0);
        send_segment(next_index, 16'd0, 1'b1, 1'b0);
        send_segment(next_index, 16'd1, 1'b0, 1'b0);
        send_segment(16'hABCD, 16'hFFFF, 1'b1, 1'b0);
        send_segment(next_index + 16'd3, 16'd2, 1'b0, 1'b1);
        send_segment(good_index(), 16'd7, 1'b0, 1'b0);
    endtask

    // Payload limit and buffer size at their edges, with the limit register
    // at reset, at both extremes and back.
    task automatic test_length_limits();
        send_segment(good_index(), MAX_PAYLOAD_RESET + 16'd2, 1'b0, 1'b0);
        send_segment(good_index(), MAX_PAYLOAD_RESET + 16'd3, 1'b0, 1'b0);
        send_segment(good_index(), LEN_W'(MAX_LEN_FIELD + 1), 1'b0, 1'b0);
        write_max_payload(9'd494);
        send_segment(good_index(), LEN_W'(MAX_LEN_FIELD), 1'b0, 1'b0);
        send_segment(good_index(), LEN_W'(MAX_LEN_FIELD + 1), 1'b0, 1'b0);
        write_max_payload(9'd0);
        send_segment(good_index(), 16'd2, 1'b0, 1'b0);
        send_segment(good_index(), 16'd3, 1'b0, 1'b0);
        write_max_payload(MAX_PAYLOAD_RESET);
    endtask

    // Receiver holds off for a long stretch while short segments stream in
    // back to back, so the held verdict stalls the input.
    task automatic test_input_stall();
        sender_idles = 1'b0;
        hold_request = 1'b1;
        repeat (10)
            send_segment(good_index(), LEN_W'($urandom_range(2, 6)), 1'b0, 1'b0);
        wait_until_idle();
        sender_idles = 1'b1;
    endtask

    // Random stream over several limit settings: mostly well-formed segments
    // with random content, the rest faulty segments and raw noise.
    task automatic test_random_stream();
        int budget;
        int kind;
        int len;
        int hi;
        int start;
        budget = RANDOM_BYTES / RANDOM_PHASES;
        len    = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       write_max_payload(9'd0);
                1:       write_max_payload(9'd494);
                5:       write_max_payload(MAX_PAYLOAD_RESET);
                default: write_max_payload(MAXP_W'($urandom_range(1, 493)));
            endcase
            sender_idles   = (ph != 1 && ph != 3);
            receiver_idles = (ph != 3 && ph != 4);
            start          = bytes_sent;
            while (bytes_sent - start < budget)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 70)
                begin
                    len = pick_payload() + 2;
                    send_segment(good_index(), LEN_W'(len), 1'b0, 1'b0);
                end
                else if (kind < 78)
                begin
                    len = pick_payload() + 2;
                    send_segment(good_index(), LEN_W'(len), 1'b0, 1'b1);
                end
                else if (kind < 83)
                begin
                    len = pick_payload() + 2;
                    send_segment(good_index(), LEN_W'(len), 1'b1, 1'($urandom_range(0, 1)));
                end
                else if (kind < 88)
                begin
                    len = pick_payload() + 2;
                    if (next_index != 0)
                        send_segment(next_index ^ INDEX_W'($urandom_range(1, 16'hFFFF)),
                                     LEN_W'(len), 1'b0, 1'b0);
                    else
                        send_segment(good_index(), LEN_W'(len), 1'b0, 1'b0);
                end
                else if (kind < 92)
                begin
                    // Length below two, or a payload just past the limit.
                    case ($urandom_range(0, 2))
                        0:       len = 0;
                        1:       len = 1;
                        default:
                        begin
                            if (int'(max_payload) + 2 < MAX_LEN_FIELD)
                            begin
                                hi  = int'(max_payload) + 40;
                                hi  = (hi > MAX_LEN_FIELD) ? MAX_LEN_FIELD : hi;
                                len = $urandom_range(int'(max_payload) + 3, hi);
                            end
                            else
                                len = 0;
                        end
                    endcase
                    send_segment(good_index(), LEN_W'(len), $urandom_range(0, 3) == 0, 1'b0);
                end
                else if (kind < 95)
                    send_segment(INDEX_W'($urandom_range(0, 16'hFFFF)),
                                 LEN_W'($urandom_range(MAX_LEN_FIELD + 1, 16'hFFFF)),
                                 1'b0, 1'b0);
                else
                begin
                    // Raw noise, then zero bytes until a header boundary.
                    repeat ($urandom_range(1, 20))
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                    while (!(rx_phase == PHASE_HEADER && rx_count == 0))
                        send_byte(8'h00);
                end
            end
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // Receiver side: per-verdict back-pressure and comparison of each
    // transfer with the oldest queued verdict.
    initial
    begin : verdict_checker
        int      gap;
        result_t want;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                gap = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected verdict, expected none, actual status %0d index %h",
                         $time, status, segment_index);
                error_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, status);
                    error_count++;
                end
                if (segment_index !== want.index)
                begin
                    $display("%0t: segment_index mismatch, expected %h, actual %h",
                             $time, want.index, segment_index);
                    error_count++;
                end
            end
        end
    end

    // Reset, the tests in turn, then the verdict.
    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        max_payload = MAX_PAYLOAD_RESET;
        rx_length   = '0;
        hdr_index   = '0;
        next_index  = '0;
        rx_restart();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_index_sequence();
        test_segment_errors();
        test_length_limits();
        test_input_stall();
        test_random_stream();
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && verdict_q.size() == 0)
            $display("[firmware_segment_receiver] OK");
        else
            $display("[firmware_segment_receiver] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/fsr_pkg.sv
src/fsr_in_reg.sv
src/fsr_core.sv
src/fsr_out_reg.sv
src/firmware_segment_receiver.sv
test/tb_firmware_segment_receiver.sv
